[src/mrm_pkg.sv]
// Shared constants and response word tables for the modem response matcher.
`timescale 1ns / 1ps

package mrm_pkg;

    localparam int WORD_SLOTS   = 16;
    localparam int MAX_WORD_LEN = 12;
    localparam int SLOT_W       = 4;
    localparam int POS_W        = 4;
    localparam int CODE_W       = 3;
    localparam int TEXT_W       = 8 * MAX_WORD_LEN;

    typedef logic [7:0]        byte_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef logic [TEXT_W-1:0] text_t;

    // Word text is right aligned: the last character sits in the low byte.
    function automatic text_t word_text(input slot_t slot);
        text_t text;
        case (slot)
            4'd0:    text = TEXT_W'("OK");
            4'd1:    text = TEXT_W'("+CPIN: READY");
            4'd2:    text = TEXT_W'("ERROR");
            4'd3:    text = TEXT_W'("RING");
            4'd4:    text = TEXT_W'("NO CARRIER");
            4'd5:    text = TEXT_W'("Unlink");
            default: text = '0;
        endcase
        return text;
    endfunction

    function automatic pos_t word_len(input slot_t slot);
        pos_t len;
        case (slot)
            4'd0:    len = 4'd2;
            4'd1:    len = 4'd12;
            4'd2:    len = 4'd5;
            4'd3:    len = 4'd4;
            4'd4:    len = 4'd10;
            4'd5:    len = 4'd6;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    // Character at position pos of a word; pos must be below the word length.
    function automatic byte_t word_char(input slot_t slot, input pos_t pos);
        text_t text;
        pos_t  idx;
        text = word_text(slot);
        idx  = word_len(slot) - 4'd1 - pos;
        return text[{idx, 3'b000} +: 8];
    endfunction

endpackage

[src/mrm_word_cell.sv]
// Progress counter and character compare for one response word.
`timescale 1ns / 1ps

module mrm_word_cell
    import mrm_pkg::*;
#(
    parameter int SLOT = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  logic  clear,
    input  byte_t rx_byte,
    output logic  done
);

    localparam slot_t SLOT_ID = SLOT_W'(SLOT);
    localparam pos_t  LEN     = word_len(SLOT_ID);

    pos_t progress_reg;
    pos_t progress_next;

    always_comb
    begin
        progress_next = '0;
        done          = 1'b0;
        if (LEN != '0 && progress_reg < LEN)
        begin
            if (word_char(SLOT_ID, progress_reg) == rx_byte)
            begin
                progress_next = progress_reg + 4'd1;
                done          = (progress_next == LEN);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            progress_reg <= '0;
        end
        else if (step)
        begin
            progress_reg <= clear ? '0 : progress_next;
        end
    end

endmodule

[src/mrm_priority.sv]
// Picks the highest word index that finished on the current byte.
`timescale 1ns / 1ps

module mrm_priority
    import mrm_pkg::*;
#(
    parameter int NUM_WORDS = 6
)
(
    input  logic [NUM_WORDS-1:0] done,
    output logic                 hit,
    output code_t                code
);

    always_comb
    begin
        hit  = 1'b0;
        code = '0;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            if (done[i])
            begin
                hit  = 1'b1;
                code = CODE_W'(i);
            end
        end
    end

endmodule

[src/modem_response_matcher.sv]
// Top level of the modem response matcher.
`timescale 1ns / 1ps

// The block watches received modem bytes for the response words OK,
// +CPIN: READY, ERROR, RING, NO CARRIER and Unlink.
// A byte enters on the rx channel (rx_valid, rx_ready, rx_byte).
// A finished word leaves on the resp channel (resp_valid, resp_ready,
// response_code); a byte that finishes no word produces no word out.
// Each byte is held in an input register; the word compares
// and counter updates run between that register and the result register.
// The result register loads when the byte in the input register advances,
// so resp_valid rises when that byte finishes a word.
// Throughput is one byte per cycle while the receiver takes each word, set by the single compare stage.
// When the receiver stalls, the result register holds its word and the
// input register holds one more byte; then rx_ready drops.
// Reset clears all progress counters and both valid flags.

module modem_response_matcher
    import mrm_pkg::*;
#(
    parameter int NUM_WORDS = 6
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  rx_valid,
    output logic  rx_ready,
    input  byte_t rx_byte,
    output logic  resp_valid,
    input  logic  resp_ready,
    output code_t response_code
);

    logic                 in_valid_reg;
    byte_t                byte_reg;
    logic                 out_valid_reg;
    code_t                code_reg;
    logic                 advance;
    logic [NUM_WORDS-1:0] done;
    logic                 hit;
    code_t                code;

    assign advance  = in_valid_reg && (!out_valid_reg || resp_ready);
    assign rx_ready = !in_valid_reg || advance;

    for (genvar g = 0; g < NUM_WORDS; g++)
    begin : g_word
        mrm_word_cell #(
            .SLOT(g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .step    (advance),
            .clear   (hit),
            .rx_byte (byte_reg),
            .done    (done[g])
        );
    end

    mrm_priority #(
        .NUM_WORDS(NUM_WORDS)
    ) u_priority (
        .done (done),
        .hit  (hit),
        .code (code)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx_ready)
            begin
                in_valid_reg <= rx_valid;
            end
            if (advance)
            begin
                out_valid_reg <= hit;
            end
            else if (resp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_ready && rx_valid)
        begin
            byte_reg <= rx_byte;
        end
        if (advance && hit)
        begin
            code_reg <= code;
        end
    end

    assign resp_valid    = out_valid_reg;
    assign response_code = code_reg;

endmodule
